// ----- design/sale_pkg.sv -----
// shared types and constants for the shifting array list engine
package sale_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ELEM_W   = 32;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 112;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [3:0] {
    CMD_PUSH_FRONT = 4'd0,
    CMD_PUSH_BACK  = 4'd1,
    CMD_POP_FRONT  = 4'd2,
    CMD_POP_BACK   = 4'd3,
    CMD_FIND       = 4'd4,
    CMD_REMOVE     = 4'd5,
    CMD_CLEAR      = 4'd6,
    CMD_READ_AT    = 4'd7,
    CMD_WRITE_AT   = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RES,
    S_SHIFT,
    S_FIND,
    S_FRONT,
    S_BACK,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_RES,
    CAP_FRONT
  } cap_t;

  // one memory access per cycle on each port
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    elem_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } mem_req_t;

endpackage

// ----- design/shifting_array_list_engine.sv -----
// top level: command sequencer around the element store
// sequence: push_back, write_at, clear, unused codes and every rejected command go from
//   idle through S_FRONT, S_BACK and S_FIN to the result beat, pop_back and read_at pass
//   S_RES first; push_front and remove_range walk the moved elements in S_SHIFT, pop_front
//   passes S_RES and then S_SHIFT, find scans the entries in S_FIND until a hit or the end
// throughput: one command at a time, a new beat is taken only in idle; the walk speed is set by
//   the single read and single write port of the element store
// reset: synchronous active-low rst_n empties the list and drops any pending result;
//   the store contents are not cleared, the count alone bounds what is read
module shifting_array_list_engine (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[3:0], element[35:4], first_index[41:36], last_index[47:42]
  input  logic [47:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_element[31:0], front_element[63:32], back_element[95:64], hit[96],
  // hit_index[102:97], element_count[109:103], status[111:110]
  output logic [111:0] out_tdata
);

  // input beat fields
  sale_pkg::cmd_t  in_cmd;
  sale_pkg::elem_t in_elem;
  sale_pkg::idx_t  in_first;
  sale_pkg::idx_t  in_last;

  assign in_cmd   = sale_pkg::cmd_t'(in_tdata[3:0]);
  assign in_elem  = in_tdata[35:4];
  assign in_first = in_tdata[41:36];
  assign in_last  = in_tdata[47:42];

  // control state
  sale_pkg::state_t state_r, state_nxt;
  sale_pkg::cmd_t   cmd_r, cmd_nxt;
  sale_pkg::cnt_t   count_r, count_nxt;
  sale_pkg::idx_t   rd_ptr_r, rd_ptr_nxt;   // next address to read in a walk
  sale_pkg::idx_t   dst_r, dst_nxt;         // next address to write in a shift
  sale_pkg::cnt_t   rem_r, rem_nxt;         // reads left in a walk
  logic             up_r, up_nxt;           // shift direction, toward higher indices
  logic             wr_pend_r, wr_pend_nxt; // read data waiting to be written back
  logic             cmp_pend_r, cmp_pend_nxt;
  sale_pkg::idx_t   cmp_idx_r, cmp_idx_nxt;
  sale_pkg::cap_t   cap_r, cap_nxt;         // where the read issued last cycle lands
  logic             out_valid_r, out_valid_nxt;

  // payload state
  sale_pkg::elem_t   elem_r, elem_nxt;
  sale_pkg::elem_t   res_r, res_nxt;
  sale_pkg::elem_t   front_r, front_nxt;
  logic              hit_r, hit_nxt;
  sale_pkg::idx_t    hidx_r, hidx_nxt;
  sale_pkg::status_t status_r, status_nxt;
  logic [111:0]      out_data_r, out_data_nxt;

  sale_pkg::mem_req_t req;
  sale_pkg::elem_t    rd_data;
  logic               load;

  sale_mem u_mem (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // widened index compares against the count
  sale_pkg::cnt_t first_w, last_w, gap_w;
  assign first_w = sale_pkg::cnt_t'(in_first);
  assign last_w  = sale_pkg::cnt_t'(in_last);
  assign gap_w   = last_w - first_w + sale_pkg::cnt_t'(1);

  assign in_tready  = (state_r == sale_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign load       = (state_r == sale_pkg::S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    count_nxt    = count_r;
    rd_ptr_nxt   = rd_ptr_r;
    dst_nxt      = dst_r;
    rem_nxt      = rem_r;
    up_nxt       = up_r;
    wr_pend_nxt  = wr_pend_r;
    cmp_pend_nxt = cmp_pend_r;
    cmp_idx_nxt  = cmp_idx_r;
    cap_nxt      = sale_pkg::CAP_NONE;
    elem_nxt     = elem_r;
    res_nxt      = res_r;
    front_nxt    = front_r;
    hit_nxt      = hit_r;
    hidx_nxt     = hidx_r;
    status_nxt   = status_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    req          = '0;

    // capture the read issued in the previous cycle
    unique case (cap_r)
      sale_pkg::CAP_RES:   res_nxt   = rd_data;
      sale_pkg::CAP_FRONT: front_nxt = rd_data;
      default: ;
    endcase

    unique case (state_r)
      sale_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt    = in_cmd;
          elem_nxt   = in_elem;
          res_nxt    = '0;
          hit_nxt    = 1'b0;
          hidx_nxt   = '0;
          status_nxt = sale_pkg::ST_OK;
          state_nxt  = sale_pkg::S_FRONT;
          unique case (in_cmd)
            sale_pkg::CMD_PUSH_FRONT: begin
              if (count_r == sale_pkg::cnt_t'(sale_pkg::CAPACITY)) begin
                status_nxt = sale_pkg::ST_FULL;
              end else begin
                // walk from the back down, each entry moves up one place
                rd_ptr_nxt  = sale_pkg::idx_t'(count_r - sale_pkg::cnt_t'(1));
                dst_nxt     = sale_pkg::idx_t'(count_r);
                rem_nxt     = count_r;
                up_nxt      = 1'b1;
                wr_pend_nxt = 1'b0;
                count_nxt   = count_r + sale_pkg::cnt_t'(1);
                state_nxt   = sale_pkg::S_SHIFT;
              end
            end
            sale_pkg::CMD_PUSH_BACK: begin
              if (count_r == sale_pkg::cnt_t'(sale_pkg::CAPACITY)) begin
                status_nxt = sale_pkg::ST_FULL;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = sale_pkg::idx_t'(count_r);
                req.wr_data = in_elem;
                count_nxt   = count_r + sale_pkg::cnt_t'(1);
              end
            end
            sale_pkg::CMD_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = sale_pkg::ST_EMPTY;
              end else begin
                rd_ptr_nxt = '0;
                count_nxt  = count_r - sale_pkg::cnt_t'(1);
                state_nxt  = sale_pkg::S_RES;
              end
            end
            sale_pkg::CMD_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = sale_pkg::ST_EMPTY;
              end else begin
                rd_ptr_nxt = sale_pkg::idx_t'(count_r - sale_pkg::cnt_t'(1));
                count_nxt  = count_r - sale_pkg::cnt_t'(1);
                state_nxt  = sale_pkg::S_RES;
              end
            end
            sale_pkg::CMD_FIND: begin
              rd_ptr_nxt   = '0;
              rem_nxt      = count_r;
              cmp_pend_nxt = 1'b0;
              state_nxt    = sale_pkg::S_FIND;
            end
            sale_pkg::CMD_REMOVE: begin
              if (in_first > in_last || last_w >= count_r) begin
                status_nxt = sale_pkg::ST_BAD;
              end else begin
                // tail above the range moves down over the gap
                rd_ptr_nxt  = sale_pkg::idx_t'(last_w + sale_pkg::cnt_t'(1));
                dst_nxt     = in_first;
                rem_nxt     = count_r - last_w - sale_pkg::cnt_t'(1);
                up_nxt      = 1'b0;
                wr_pend_nxt = 1'b0;
                count_nxt   = count_r - gap_w;
                state_nxt   = sale_pkg::S_SHIFT;
              end
            end
            sale_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            sale_pkg::CMD_READ_AT: begin
              if (first_w >= count_r) begin
                status_nxt = sale_pkg::ST_BAD;
              end else begin
                rd_ptr_nxt = in_first;
                state_nxt  = sale_pkg::S_RES;
              end
            end
            sale_pkg::CMD_WRITE_AT: begin
              if (first_w >= count_r) begin
                status_nxt = sale_pkg::ST_BAD;
              end else begin
                req.wr_en   = 1'b1;
                req.wr_addr = in_first;
                req.wr_data = in_elem;
              end
            end
            default: ;  // unused codes leave the list alone
          endcase
        end
      end

      // fetch the element returned by a pop or read
      sale_pkg::S_RES: begin
        req.rd_en   = 1'b1;
        req.rd_addr = rd_ptr_r;
        cap_nxt     = sale_pkg::CAP_RES;
        if (cmd_r == sale_pkg::CMD_POP_FRONT) begin
          rd_ptr_nxt  = sale_pkg::idx_t'(1);
          dst_nxt     = '0;
          rem_nxt     = count_r;  // already one less than before the pop
          up_nxt      = 1'b0;
          wr_pend_nxt = 1'b0;
          state_nxt   = sale_pkg::S_SHIFT;
        end else begin
          state_nxt = sale_pkg::S_FRONT;
        end
      end

      // read one entry, write the previous one back one or gap places away
      sale_pkg::S_SHIFT: begin
        if (rem_r != '0) begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_ptr_r;
          rd_ptr_nxt  = up_r ? rd_ptr_r - sale_pkg::idx_t'(1) : rd_ptr_r + sale_pkg::idx_t'(1);
          rem_nxt     = rem_r - sale_pkg::cnt_t'(1);
          wr_pend_nxt = 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
        end
        if (wr_pend_r) begin
          req.wr_en   = 1'b1;
          req.wr_addr = dst_r;
          req.wr_data = rd_data;
          dst_nxt     = up_r ? dst_r - sale_pkg::idx_t'(1) : dst_r + sale_pkg::idx_t'(1);
        end else if (rem_r == '0) begin
          // walk done; a front push drops its element into the opened slot
          if (cmd_r == sale_pkg::CMD_PUSH_FRONT) begin
            req.wr_en   = 1'b1;
            req.wr_addr = '0;
            req.wr_data = elem_r;
          end
          state_nxt = sale_pkg::S_FRONT;
        end
      end

      // scan upward, compare each entry in the cycle after its read
      sale_pkg::S_FIND: begin
        if (rem_r != '0) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = rd_ptr_r;
          rd_ptr_nxt   = rd_ptr_r + sale_pkg::idx_t'(1);
          rem_nxt      = rem_r - sale_pkg::cnt_t'(1);
          cmp_pend_nxt = 1'b1;
          cmp_idx_nxt  = rd_ptr_r;
        end else begin
          cmp_pend_nxt = 1'b0;
        end
        if (cmp_pend_r && rd_data == elem_r) begin
          hit_nxt      = 1'b1;
          hidx_nxt     = cmp_idx_r;
          cmp_pend_nxt = 1'b0;
          state_nxt    = sale_pkg::S_FRONT;
        end else if (rem_r == '0 && !cmp_pend_r) begin
          state_nxt = sale_pkg::S_FRONT;
        end
      end

      sale_pkg::S_FRONT: begin
        req.rd_en   = 1'b1;
        req.rd_addr = '0;
        cap_nxt     = sale_pkg::CAP_FRONT;
        state_nxt   = sale_pkg::S_BACK;
      end

      // back entry read data stays in the store register until the beat loads
      sale_pkg::S_BACK: begin
        req.rd_en   = 1'b1;
        req.rd_addr = sale_pkg::idx_t'(count_r - sale_pkg::cnt_t'(1));
        state_nxt   = sale_pkg::S_FIN;
      end

      sale_pkg::S_FIN: begin
        if (load) begin
          out_data_nxt[31:0]    = res_r;
          out_data_nxt[63:32]   = (count_r != '0) ? front_nxt : '0;
          out_data_nxt[95:64]   = (count_r != '0) ? rd_data : '0;
          out_data_nxt[96]      = hit_r;
          out_data_nxt[102:97]  = hidx_r;
          out_data_nxt[109:103] = count_r;
          out_data_nxt[111:110] = status_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = sale_pkg::S_IDLE;
        end
      end

      default: state_nxt = sale_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sale_pkg::S_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      cmp_pend_r  <= 1'b0;
      cap_r       <= sale_pkg::CAP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      cmp_pend_r  <= cmp_pend_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    dst_r      <= dst_nxt;
    rem_r      <= rem_nxt;
    up_r       <= up_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    elem_r     <= elem_nxt;
    res_r      <= res_nxt;
    front_r    <= front_nxt;
    hit_r      <= hit_nxt;
    hidx_r     <= hidx_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // the count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sale_pkg::cnt_t'(sale_pkg::CAPACITY))
    else $error("element count above capacity");

  // an accepted beat always takes the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r != sale_pkg::S_IDLE)
    else $error("sequencer stayed idle after an input beat");

  // full is only reported while the list is at capacity
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (load && status_r == sale_pkg::ST_FULL) |->
      count_r == sale_pkg::cnt_t'(sale_pkg::CAPACITY))
    else $error("full status with room left");

  // a write-back never lands on the entry being read in the same cycle
  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && req.rd_en) |-> req.wr_addr != req.rd_addr)
    else $error("read and write of the same entry in one cycle");

endmodule

// ----- design/sale_mem.sv -----
// element store: one write port, one read port with registered read data
module sale_mem (
  input  logic              clk,
  input  sale_pkg::mem_req_t req,
  output sale_pkg::elem_t   rd_data
);

  sale_pkg::elem_t mem [sale_pkg::CAPACITY];
  sale_pkg::elem_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
